// File: design/ftrl_logistic_regression_trainer_top_macros.svh
// Assertion macros for the FTRL trainer top level.
`ifndef FTRL_LOGISTIC_REGRESSION_TRAINER_TOP_MACROS_SVH
`define FTRL_LOGISTIC_REGRESSION_TRAINER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define FTRL_ASSERT_IMPL(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define FTRL_ASSERT_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: design/ftrl_pkg.sv
// Shared constants, types and the sigmoid table for the FTRL trainer.
package ftrl_pkg;

   localparam int MODEL_SIZE_DEF   = 4096;
   localparam int MAX_FEATURES_DEF = 64;

   localparam int SQ_RAD_W   = 48;
   localparam int SQ_ROOT_W  = 24;
   localparam int DIV_NUM_W  = 48;
   localparam int DIV_DEN_W  = 42;

   localparam logic [1:0] CSR_L1    = 2'd0;
   localparam logic [1:0] CSR_L2    = 2'd1;
   localparam logic [1:0] CSR_ALPHA = 2'd2;
   localparam logic [1:0] CSR_BETA  = 2'd3;

   localparam logic [23:0] L1_RESET    = 24'd65536;
   localparam logic [23:0] L2_RESET    = 24'd65536;
   localparam logic [23:0] ALPHA_RESET = 24'd6554;
   localparam logic [23:0] BETA_RESET  = 24'd65536;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [15:0] SIG_SAT = 16'd65514;
   localparam logic [15:0] SIG_POINTS [17] = '{
      16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
      16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
      16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
   };

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_P1_RD, ST_P1_MRD, ST_P1_MDAT, ST_P1_SHR, ST_P1_SQRT, ST_P1_DIVA,
      ST_P1_DSTART, ST_P1_DIVB, ST_P1_WR, ST_P1_MAC, ST_P1_ACC,
      ST_SIG_ABS, ST_SIG_EVAL,
      ST_P2_RD, ST_P2_MRD, ST_P2_MDAT, ST_P2_GG, ST_P2_SQ0, ST_P2_SQ1S,
      ST_P2_SQ1, ST_P2_DIV, ST_P2_MUL, ST_P2_Z
   } state_type;

   // piecewise-linear sigmoid on |x| < 8, segments of 0.5
   function automatic logic [15:0] sig_interp(input logic [3:0] seg,
                                              input logic [14:0] frac);
      logic [15:0] lo;
      logic [15:0] hi;
      logic [12:0] dlt;
      logic [27:0] prod;
      lo   = SIG_POINTS[seg];
      hi   = SIG_POINTS[5'({1'b0, seg} + 5'd1)];
      dlt  = 13'(hi - lo);
      prod = 28'(dlt) * 28'(frac);
      return lo + 16'(prod >> 15);
   endfunction

endpackage

// File: design/ftrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ftrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ftrl_sqrt.sv
// Iterative integer square root, one root bit per cycle.
module ftrl_sqrt import ftrl_pkg::*; #(
   parameter int RAD_W  = SQ_RAD_W,
   parameter int ROOT_W = SQ_ROOT_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int CW = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   logic [ROOT_W+1:0] remx;
   logic [ROOT_W+1:0] trial;
   logic [ROOT_W+1:0] diff;
   logic              ge;

   assign remx  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial = {root_ff, 2'b01};
   assign ge    = remx >= trial;
   assign diff  = remx - trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(ROOT_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = ROOT_W'(ge ? diff : remx);
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: design/ftrl_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ftrl_div import ftrl_pkg::*; #(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           ge;

   // quotient bits shift in where the numerator bits shift out
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = CW'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], ge};
         rem_in = DEN_W'(ge ? diff : trial);
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// File: design/ftrl_logistic_regression_trainer_top.sv
// Top level of the FTRL-Proximal logistic regression trainer and predictor.
//
// Feature words enter on req_* with start; a word is taken when start is high
// and busy is low. In-range words are buffered, one per cycle, up to the word
// with req_last_feature set, which carries cmd and label for the instance.
// One result word (rsp_probability, rsp_status) follows each last word,
// strobed by rsp_valid for one cycle; the receiver cannot stall it.
// Rejected instances answer in the cycle after the last word, busy stays low.
// Predict: each buffered feature is read, weighted and summed, then the sum
// passes the sigmoid. Train adds a z and n update pass and uses the shared
// square-root unit (24 steps) and divider (48 steps), each up to three runs.
// Weights, z and n live in one RAM read and written back one feature at a
// time, so repeated indexes always see the previous write.
// After reset the model RAM is swept to zero, entry by entry, with busy
// high; csr writes (csr_ready always high) are taken at any time but belong
// to idle periods.
`include "ftrl_logistic_regression_trainer_top_macros.svh"

module ftrl_logistic_regression_trainer_top import ftrl_pkg::*; #(
   parameter int MODEL_SIZE   = MODEL_SIZE_DEF,
   parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_feature_index,
   input  logic signed [15:0] req_feature_value,
   input  logic        req_label,
   input  logic        req_last_feature,
   output logic        rsp_valid,
   output logic [15:0] rsp_probability,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int AW    = (MODEL_SIZE > 1) ? $clog2(MODEL_SIZE) : 1;
   localparam int BW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CNT_W = $clog2(MAX_FEATURES + 1);
   localparam int SUM_W = 48 + CNT_W;
   localparam int BUF_W = AW + 16;

   // configuration
   logic [23:0] l1_ff, l1_in, l2_ff, l2_in, alpha_ff, alpha_in, beta_ff, beta_in;
   logic [23:0] alpha_eff;

   // control
   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, k_ff, k_in;
   logic [1:0]      rej_ff, rej_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // datapath
   logic                    cmd_ff, cmd_in, label_ff, label_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic signed [15:0]      val_ff, val_in;
   logic signed [31:0]      w_ff, w_in, z_ff, z_in;
   logic [31:0]             n_ff, n_in, az_ff, az_in;
   logic [41:0]             d_ff, d_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [47:0]      prod_ff, prod_in;
   logic [SUM_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [15:0]             p_ff, p_in;
   logic signed [32:0]      g_ff, g_in;
   logic [31:0]             ag_ff, ag_in;
   logic [47:0]             gg_ff, gg_in;
   logic [23:0]             sold_ff, sold_in;
   logic [31:0]             nnew_ff, nnew_in;
   logic [30:0]             sigma_ff, sigma_in;
   logic [46:0]             tm_ff, tm_in;
   logic [15:0]             rsp_prob_ff, rsp_prob_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;

   // memories
   logic             mem_we;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [95:0]      mem_wdata, mem_rdata;
   logic             buf_we;
   logic [BW-1:0]    buf_waddr, buf_raddr;
   logic [BUF_W-1:0] buf_wdata, buf_rdata;

   // shared units
   logic        sq_start, sq_done;
   logic [47:0] sq_rad;
   logic [23:0] sq_root;
   logic        div_start, div_done;
   logic [47:0] div_num, div_quot;
   logic [41:0] div_den;

   // helpers
   logic               accept, in_range, full, good_last;
   logic [1:0]         code_now;
   logic signed [15:0] buf_val;
   logic signed [17:0] pl;
   logic signed [32:0] g_calc;
   logic [15:0]        sig_y;
   logic [48:0]        nsum;
   logic [31:0]        wmag;
   logic [62:0]        tmul;
   logic [63:0]        sq_ag;
   logic signed [47:0] term;
   logic signed [49:0] zsum;
   logic signed [31:0] z_new;
   logic [30:0]        q_clamp;

   assign alpha_eff = (alpha_ff == 24'd0) ? 24'd1 : alpha_ff;
   assign busy      = state_ff != ST_IDLE;
   assign accept    = start && !busy;
   assign in_range  = {1'b0, req_feature_index} < 17'(MODEL_SIZE);
   assign full      = cnt_ff == CNT_W'(MAX_FEATURES);
   assign code_now  = (rej_ff != STATUS_OK) ? rej_ff :
                      (!in_range ? STATUS_RANGE : (full ? STATUS_OVERFLOW : STATUS_OK));
   assign good_last = accept && req_last_feature && (code_now == STATUS_OK);

   assign buf_val   = buf_rdata[15:0];
   assign buf_raddr = k_ff[BW-1:0];
   assign buf_waddr = cnt_ff[BW-1:0];
   assign buf_wdata = {req_feature_index[AW-1:0], req_feature_value};
   assign buf_we    = accept && in_range && !full;
   assign mem_raddr = buf_rdata[BUF_W-1:16];

   assign pl     = $signed({2'b00, p_ff}) - (label_ff ? 18'sd65536 : 18'sd0);
   assign g_calc = 33'(pl) * 33'(buf_val);
   assign sig_y  = (|mag_ff[SUM_W-1:19]) ? SIG_SAT : sig_interp(mag_ff[18:15], mag_ff[14:0]);
   assign nsum   = {17'd0, n_ff} + {1'b0, gg_ff};
   assign wmag   = w_ff[31] ? 32'(-w_ff) : 32'(w_ff);
   assign tmul   = 63'(sigma_ff) * 63'(wmag);
   assign sq_ag  = 64'(ag_ff) * 64'(ag_ff);
   assign term   = w_ff[31] ? -$signed({1'b0, tm_ff}) : $signed({1'b0, tm_ff});
   assign zsum   = 50'(z_ff) + 50'(g_ff) - 50'(term);
   assign z_new  = (zsum > 50'sd2147483647) ? 32'sh7FFFFFFF :
                   (zsum < -50'sd2147483648) ? 32'sh80000000 : 32'(zsum);
   assign q_clamp = (|div_quot[47:31]) ? 31'h7FFFFFFF : div_quot[30:0];

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      rej_in        = rej_ff;
      rsp_valid_in  = 1'b0;
      rsp_prob_in   = rsp_prob_ff;
      rsp_status_in = rsp_status_ff;
      cmd_in        = cmd_ff;
      label_in      = label_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      w_in          = w_ff;
      z_in          = z_ff;
      n_in          = n_ff;
      az_in         = az_ff;
      d_in          = d_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      p_in          = p_ff;
      g_in          = g_ff;
      ag_in         = ag_ff;
      gg_in         = gg_ff;
      sold_in       = sold_ff;
      nnew_in       = nnew_ff;
      sigma_in      = sigma_ff;
      tm_in         = tm_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = {w_ff, z_ff, n_ff};
      sq_start      = 1'b0;
      sq_rad        = {n_ff, 16'd0};
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = 42'(alpha_eff);

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MODEL_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (buf_we) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (!req_last_feature) begin
                  rej_in = code_now;
               end else if (code_now != STATUS_OK) begin
                  rsp_valid_in  = 1'b1;
                  rsp_prob_in   = '0;
                  rsp_status_in = code_now;
                  cnt_in        = '0;
                  rej_in        = STATUS_OK;
               end else begin
                  cmd_in   = req_cmd;
                  label_in = req_label;
                  k_in     = '0;
                  sum_in   = '0;
                  state_in = ST_P1_RD;
               end
            end
         end
         ST_P1_RD: state_in = ST_P1_MRD;
         ST_P1_MRD: begin
            idx_in   = mem_raddr;
            val_in   = buf_val;
            state_in = ST_P1_MDAT;
         end
         ST_P1_MDAT: begin
            w_in  = mem_rdata[95:64];
            z_in  = mem_rdata[63:32];
            n_in  = mem_rdata[31:0];
            az_in = mem_rdata[63] ? 32'(-$signed(mem_rdata[63:32])) : mem_rdata[63:32];
            state_in = cmd_ff ? ST_P1_MAC : ST_P1_SHR;
         end
         ST_P1_SHR: begin
            if (az_ff < 32'(l1_ff)) begin
               w_in     = '0;
               state_in = ST_P1_WR;
            end else begin
               sq_start = 1'b1;
               state_in = ST_P1_SQRT;
            end
         end
         ST_P1_SQRT: begin
            if (sq_done) begin
               div_start = 1'b1;
               div_num   = 48'({25'(beta_ff) + 25'(sq_root), 16'd0});
               state_in  = ST_P1_DIVA;
            end
         end
         ST_P1_DIVA: begin
            if (div_done) begin
               d_in     = 42'(div_quot[40:0]) + 42'(l2_ff);
               state_in = ST_P1_DSTART;
            end
         end
         ST_P1_DSTART: begin
            if (d_ff == '0) begin
               // zero denominator saturates unless the shrunk magnitude is zero
               if (az_ff == 32'(l1_ff)) begin
                  w_in = '0;
               end else begin
                  w_in = (z_ff > 0) ? -32'sh7FFFFFFF : 32'sh7FFFFFFF;
               end
               state_in = ST_P1_WR;
            end else begin
               div_start = 1'b1;
               div_num   = {az_ff - 32'(l1_ff), 16'd0};
               div_den   = d_ff;
               state_in  = ST_P1_DIVB;
            end
         end
         ST_P1_DIVB: begin
            if (div_done) begin
               w_in     = (z_ff > 0) ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
               state_in = ST_P1_WR;
            end
         end
         ST_P1_WR: begin
            mem_we   = 1'b1;
            state_in = ST_P1_MAC;
         end
         ST_P1_MAC: begin
            prod_in  = 48'(val_ff) * 48'(w_ff);
            state_in = ST_P1_ACC;
         end
         ST_P1_ACC: begin
            sum_in = sum_ff + SUM_W'(prod_ff);
            k_in   = k_ff + CNT_W'(1);
            state_in = (k_ff + CNT_W'(1) == cnt_ff) ? ST_SIG_ABS : ST_P1_RD;
         end
         ST_SIG_ABS: begin
            neg_in   = sum_ff < 0;
            mag_in   = (sum_ff < 0) ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
            state_in = ST_SIG_EVAL;
         end
         ST_SIG_EVAL: begin
            p_in = neg_ff ? 16'(17'h10000 - {1'b0, sig_y}) : sig_y;
            if (cmd_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_prob_in   = neg_ff ? 16'(17'h10000 - {1'b0, sig_y}) : sig_y;
               rsp_status_in = STATUS_OK;
               cnt_in        = '0;
               state_in      = ST_IDLE;
            end else begin
               k_in     = '0;
               state_in = ST_P2_RD;
            end
         end
         ST_P2_RD: state_in = ST_P2_MRD;
         ST_P2_MRD: begin
            idx_in   = mem_raddr;
            val_in   = buf_val;
            g_in     = g_calc;
            state_in = ST_P2_MDAT;
         end
         ST_P2_MDAT: begin
            w_in     = mem_rdata[95:64];
            z_in     = mem_rdata[63:32];
            n_in     = mem_rdata[31:0];
            ag_in    = g_ff[32] ? 32'(-g_ff) : 32'(g_ff);
            state_in = ST_P2_GG;
         end
         ST_P2_GG: begin
            gg_in    = sq_ag[63:16];
            sq_start = 1'b1;
            state_in = ST_P2_SQ0;
         end
         ST_P2_SQ0: begin
            if (sq_done) begin
               sold_in  = sq_root;
               nnew_in  = (|nsum[48:32]) ? 32'hFFFFFFFF : nsum[31:0];
               state_in = ST_P2_SQ1S;
            end
         end
         ST_P2_SQ1S: begin
            sq_start = 1'b1;
            sq_rad   = {nnew_ff, 16'd0};
            state_in = ST_P2_SQ1;
         end
         ST_P2_SQ1: begin
            if (sq_done) begin
               div_start = 1'b1;
               div_num   = 48'({sq_root - sold_ff, 16'd0});
               state_in  = ST_P2_DIV;
            end
         end
         ST_P2_DIV: begin
            if (div_done) begin
               sigma_in = q_clamp;
               state_in = ST_P2_MUL;
            end
         end
         ST_P2_MUL: begin
            tm_in    = tmul[62:16];
            state_in = ST_P2_Z;
         end
         ST_P2_Z: begin
            mem_we    = 1'b1;
            mem_wdata = {w_ff, z_new, nnew_ff};
            k_in      = k_ff + CNT_W'(1);
            if (k_ff + CNT_W'(1) == cnt_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_prob_in   = p_ff;
               rsp_status_in = STATUS_OK;
               cnt_in        = '0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_P2_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      l1_in    = l1_ff;
      l2_in    = l2_ff;
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_L1:    l1_in    = csr_wdata;
            CSR_L2:    l2_in    = csr_wdata;
            CSR_ALPHA: alpha_in = csr_wdata;
            CSR_BETA:  beta_in  = csr_wdata;
            default:   l1_in    = l1_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rej_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
         l1_ff        <= L1_RESET;
         l2_ff        <= L2_RESET;
         alpha_ff     <= ALPHA_RESET;
         beta_ff      <= BETA_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
         l1_ff        <= l1_in;
         l2_ff        <= l2_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      label_ff      <= label_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      w_ff          <= w_in;
      z_ff          <= z_in;
      n_ff          <= n_in;
      az_ff         <= az_in;
      d_ff          <= d_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      p_ff          <= p_in;
      g_ff          <= g_in;
      ag_ff         <= ag_in;
      gg_ff         <= gg_in;
      sold_ff       <= sold_in;
      nnew_ff       <= nnew_in;
      sigma_ff      <= sigma_in;
      tm_ff         <= tm_in;
      rsp_prob_ff   <= rsp_prob_in;
      rsp_status_ff <= rsp_status_in;
   end

   // weight, z, n per model entry
   ftrl_ram #(.WIDTH(96), .DEPTH(MODEL_SIZE)) u_model_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // index and value of each buffered feature
   ftrl_ram #(.WIDTH(BUF_W), .DEPTH(MAX_FEATURES)) u_inst_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   ftrl_sqrt #(.RAD_W(SQ_RAD_W), .ROOT_W(SQ_ROOT_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   ftrl_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_status      = rsp_status_ff;
   assign csr_ready       = 1'b1;

   `FTRL_ASSERT_IMPL(a_rsp_in_idle, rsp_valid_ff, state_ff == ST_IDLE, "result word outside idle")
   `FTRL_ASSERT_NEXT(a_last_goes_busy, good_last, busy, "good last word did not start")
   `FTRL_ASSERT_IMPL(a_reject_zero_prob, rsp_valid_ff && rsp_status_ff != STATUS_OK,
                     rsp_prob_ff == 16'd0, "rejected word with nonzero probability")

endmodule
